### rtl/core/ps2sc_pkg.sv
package ps2sc_pkg;

	// Set 2 codes with a fixed meaning
	localparam logic [7:0] CODE_BREAK  = 8'hF0;
	localparam logic [7:0] CODE_EXT    = 8'hE0;
	localparam logic [7:0] CODE_LSHIFT = 8'h12;
	localparam logic [7:0] CODE_RSHIFT = 8'h59;
	localparam logic [7:0] CODE_CTRL   = 8'h14;
	localparam logic [7:0] CODE_CAPS   = 8'h58;
	localparam logic [7:0] CODE_ESC    = 8'h76;
	localparam logic [7:0] CODE_UP     = 8'h75;
	localparam logic [7:0] CODE_DOWN   = 8'h72;
	localparam logic [7:0] CODE_LEFT   = 8'h6B;
	localparam logic [7:0] CODE_RIGHT  = 8'h74;

	// Characters emitted for the forced keys
	localparam logic [7:0] CHAR_ESC   = 8'd27;
	localparam logic [7:0] CHAR_UP    = 8'd129;
	localparam logic [7:0] CHAR_DOWN  = 8'd130;
	localparam logic [7:0] CHAR_LEFT  = 8'd131;
	localparam logic [7:0] CHAR_RIGHT = 8'd132;

	typedef struct packed {
		logic brk;
		logic shift;
		logic ctrl;
		logic caps;
	} flags_t;

	// Result word, first field in the highest bits
	typedef struct packed {
		logic       caps_on;
		logic       ctrl_held;
		logic       shift_held;
		logic [2:0] led_value;
		logic       led_update;
		logic [7:0] char_code;
		logic       char_valid;
	} result_t;

	function automatic logic [7:0] plain_lut(input logic [6:0] idx);
		logic [7:0] c;
		case (idx)
			7'h09: c = 8'h09; 7'h0D: c = 8'h09; 7'h0E: c = 8'h60;
			7'h15: c = 8'h71; 7'h16: c = 8'h31; 7'h1A: c = 8'h7A; 7'h1B: c = 8'h73;
			7'h1C: c = 8'h61; 7'h1D: c = 8'h77; 7'h1E: c = 8'h32;
			7'h21: c = 8'h63; 7'h22: c = 8'h78; 7'h23: c = 8'h64; 7'h24: c = 8'h65;
			7'h25: c = 8'h34; 7'h26: c = 8'h33; 7'h29: c = 8'h20; 7'h2A: c = 8'h76;
			7'h2B: c = 8'h66; 7'h2C: c = 8'h74; 7'h2D: c = 8'h72; 7'h2E: c = 8'h35;
			7'h31: c = 8'h6E; 7'h32: c = 8'h62; 7'h33: c = 8'h68; 7'h34: c = 8'h67;
			7'h35: c = 8'h79; 7'h36: c = 8'h36; 7'h3A: c = 8'h6D; 7'h3B: c = 8'h6A;
			7'h3C: c = 8'h75; 7'h3D: c = 8'h37; 7'h3E: c = 8'h38;
			7'h41: c = 8'h2C; 7'h42: c = 8'h6B; 7'h43: c = 8'h69; 7'h44: c = 8'h6F;
			7'h45: c = 8'h30; 7'h46: c = 8'h39; 7'h49: c = 8'h2E; 7'h4A: c = 8'h2F;
			7'h4B: c = 8'h6C; 7'h4C: c = 8'h3B; 7'h4D: c = 8'h70; 7'h4E: c = 8'h2D;
			7'h52: c = 8'h27; 7'h54: c = 8'h5B; 7'h55: c = 8'h3D; 7'h5A: c = 8'h0A;
			7'h5B: c = 8'h5D; 7'h5D: c = 8'h5C;
			7'h66: c = 8'h08; 7'h69: c = 8'h31; 7'h6B: c = 8'h34; 7'h6C: c = 8'h37;
			7'h70: c = 8'h30; 7'h71: c = 8'h2E; 7'h72: c = 8'h32; 7'h73: c = 8'h35;
			7'h74: c = 8'h36; 7'h75: c = 8'h38; 7'h79: c = 8'h2B; 7'h7A: c = 8'h33;
			7'h7B: c = 8'h2D; 7'h7C: c = 8'h2A; 7'h7D: c = 8'h39;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shift_lut(input logic [6:0] idx);
		logic [7:0] c;
		case (idx)
			7'h09: c = 8'h09; 7'h0D: c = 8'h09; 7'h0E: c = 8'h7E;
			7'h15: c = 8'h51; 7'h16: c = 8'h21; 7'h1A: c = 8'h5A; 7'h1B: c = 8'h53;
			7'h1C: c = 8'h41; 7'h1D: c = 8'h57; 7'h1E: c = 8'h40;
			7'h21: c = 8'h43; 7'h22: c = 8'h58; 7'h23: c = 8'h44; 7'h24: c = 8'h45;
			7'h25: c = 8'h24; 7'h26: c = 8'h23; 7'h29: c = 8'h20; 7'h2A: c = 8'h56;
			7'h2B: c = 8'h46; 7'h2C: c = 8'h54; 7'h2D: c = 8'h52; 7'h2E: c = 8'h25;
			7'h31: c = 8'h4E; 7'h32: c = 8'h42; 7'h33: c = 8'h48; 7'h34: c = 8'h47;
			7'h35: c = 8'h59; 7'h36: c = 8'h5E; 7'h3A: c = 8'h4D; 7'h3B: c = 8'h4A;
			7'h3C: c = 8'h55; 7'h3D: c = 8'h26; 7'h3E: c = 8'h2A;
			7'h41: c = 8'h3C; 7'h42: c = 8'h4B; 7'h43: c = 8'h49; 7'h44: c = 8'h4F;
			7'h45: c = 8'h29; 7'h46: c = 8'h28; 7'h49: c = 8'h3E; 7'h4A: c = 8'h3F;
			7'h4B: c = 8'h4C; 7'h4C: c = 8'h3A; 7'h4D: c = 8'h50; 7'h4E: c = 8'h5F;
			7'h52: c = 8'h22; 7'h54: c = 8'h7B; 7'h55: c = 8'h2B; 7'h5A: c = 8'h0A;
			7'h5B: c = 8'h7D; 7'h5D: c = 8'h7C;
			7'h66: c = 8'h08; 7'h69: c = 8'h31; 7'h6B: c = 8'h34; 7'h6C: c = 8'h37;
			7'h70: c = 8'h30; 7'h71: c = 8'h2E; 7'h72: c = 8'h32; 7'h73: c = 8'h35;
			7'h74: c = 8'h36; 7'h75: c = 8'h38; 7'h79: c = 8'h2B; 7'h7A: c = 8'h33;
			7'h7B: c = 8'h2D; 7'h7C: c = 8'h2A; 7'h7D: c = 8'h39;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/ps2sc_decode.sv
// Next-state and result logic for one scan byte.
module ps2sc_decode (
	input  logic [7:0]        scan,
	input  ps2sc_pkg::flags_t flags,
	output ps2sc_pkg::flags_t flags_nxt,
	output ps2sc_pkg::result_t res
);

	logic [7:0] ch;
	logic [7:0] lut;
	logic       led;
	logic       is_shift;

	assign is_shift = (scan == ps2sc_pkg::CODE_LSHIFT) || (scan == ps2sc_pkg::CODE_RSHIFT);

	always_comb begin
		lut = flags.shift ? ps2sc_pkg::shift_lut(scan[6:0]) : ps2sc_pkg::plain_lut(scan[6:0]);
		if (flags.caps) begin
			if (lut inside {[8'h61:8'h7A]}) begin
				lut = lut - 8'd32;
			end else if (lut inside {[8'h41:8'h5A]}) begin
				lut = lut + 8'd32;
			end
		end
	end

	always_comb begin
		flags_nxt = flags;
		ch        = 8'h00;
		led       = 1'b0;
		if (scan == ps2sc_pkg::CODE_BREAK) begin
			flags_nxt.brk = 1'b1;
		end else if (scan == ps2sc_pkg::CODE_EXT) begin
			// extended prefix carries nothing here
		end else if (flags.brk) begin
			if (is_shift) begin
				flags_nxt.shift = 1'b0;
			end else if (scan == ps2sc_pkg::CODE_CTRL) begin
				flags_nxt.ctrl = 1'b0;
			end
			flags_nxt.brk = 1'b0;
		end else if (is_shift) begin
			flags_nxt.shift = 1'b1;
		end else if (scan == ps2sc_pkg::CODE_CTRL) begin
			flags_nxt.ctrl = 1'b1;
		end else if (scan == ps2sc_pkg::CODE_CAPS) begin
			flags_nxt.caps = ~flags.caps;
			led            = 1'b1;
		end else if (!scan[7]) begin
			case (scan)
				ps2sc_pkg::CODE_ESC:   ch = ps2sc_pkg::CHAR_ESC;
				ps2sc_pkg::CODE_UP:    ch = ps2sc_pkg::CHAR_UP;
				ps2sc_pkg::CODE_DOWN:  ch = ps2sc_pkg::CHAR_DOWN;
				ps2sc_pkg::CODE_LEFT:  ch = ps2sc_pkg::CHAR_LEFT;
				ps2sc_pkg::CODE_RIGHT: ch = ps2sc_pkg::CHAR_RIGHT;
				default:               ch = lut;
			endcase
		end
	end

	always_comb begin
		res.char_valid = (ch != 8'h00);
		res.char_code  = ch;
		res.led_update = led;
		res.led_value  = {flags_nxt.caps, 2'b00};
		res.shift_held = flags_nxt.shift;
		res.ctrl_held  = flags_nxt.ctrl;
		res.caps_on    = flags_nxt.caps;
	end

endmodule

### rtl/core/ps2_scancode_to_ascii_decoder_unit.sv
// PS/2 scan code set 2 to ASCII decoder.
// Input stream: one received set 2 byte per word on s_axis_tdata[7:0].
// Output stream: one result word per input byte, never dropped or merged.
//   char_valid/char_code give the key character (27 Esc, 129..132 arrows),
//   led_update pulses on a caps lock press; the host then sends 0xED and
//   led_value. shift_held, ctrl_held and caps_on show the modifiers after
//   the byte.
// Datapath: input register (_s1) -> decode logic and modifier flags ->
//   output register. The flags update only as a byte moves to the output
//   register, so bytes are decoded strictly in order.
// Throughput: one byte per cycle through the two register stages while m_axis_tready is high.
// Stall: when m_axis_tready is low the output word holds; the input register
//   still takes one more byte, then s_axis_tready drops until space frees.
// Reset (arst_n low, asynchronous): both stages empty, break prefix, shift,
//   ctrl and caps lock all cleared.
module ps2_scancode_to_ascii_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] scan_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] char_valid, [8:1] char_code,
	                                   // [9] led_update, [12:10] led_value,
	                                   // [13] shift_held, [14] ctrl_held,
	                                   // [15] caps_on
);

	logic               valid_s1;
	logic [7:0]         scan_s1;
	logic               out_valid_q;
	ps2sc_pkg::result_t out_q;
	ps2sc_pkg::flags_t  flags_q;
	ps2sc_pkg::flags_t  flags_nxt;
	ps2sc_pkg::result_t res;
	logic               out_free;
	logic               advance;

	// Output register can load when empty or being drained this cycle.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	ps2sc_decode u_decode (
		.scan      (scan_s1),
		.flags     (flags_q),
		.flags_nxt (flags_nxt),
		.res       (res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			scan_s1 <= s_axis_tdata;
		end
	end

	// modifier flags commit with the byte that changes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance) begin
			flags_q <= flags_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

### rtl/core/ps2sc_checker.sv
module ps2sc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// char_valid flags exactly the nonzero characters
	a_char_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[8:1] != 8'h00)))
		else $error("char_valid disagrees with char_code");

	// LED value tracks caps lock
	a_led_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[12:10] == {m_axis_tdata[15], 2'b00}))
		else $error("led_value does not match caps_on");

	// caps lock press gives no character
	a_led_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[0])
		else $error("caps lock press produced a character");

	// an empty pipeline must be able to take a byte
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |-> s_axis_tready)
		else $error("input stalled with nothing in flight");

endmodule

bind ps2_scancode_to_ascii_decoder_unit ps2sc_checker u_ps2sc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/ps2_scancode_to_ascii_decoder_unit_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the scan code decoder, predicts each result word
// from the accepted scan bytes and compares in order.
module ps2_scancode_to_ascii_decoder_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          err_count,
	output int          words_pending,
	output int          chars_seen,
	output int          leds_seen
);

	logic [7:0] plain_map [128];
	logic [7:0] shift_map [128];

	// modeled keyboard state
	logic brk_q;
	logic shift_q;
	logic ctrl_q;
	logic caps_q;

	ps2sc_pkg::result_t predicted_words [$];

	// Key maps: shifted map is the plain one with letters in upper case,
	// then the symbol keys patched.
	initial begin
		for (int i = 0; i < 128; i++) plain_map[7'(i)] = 8'h00;
		plain_map[7'h09] = 8'h09; plain_map[7'h0D] = 8'h09; plain_map[7'h0E] = 8'h60;
		plain_map[7'h15] = 8'h71; plain_map[7'h16] = 8'h31; plain_map[7'h1A] = 8'h7A;
		plain_map[7'h1B] = 8'h73; plain_map[7'h1C] = 8'h61; plain_map[7'h1D] = 8'h77;
		plain_map[7'h1E] = 8'h32; plain_map[7'h21] = 8'h63; plain_map[7'h22] = 8'h78;
		plain_map[7'h23] = 8'h64; plain_map[7'h24] = 8'h65; plain_map[7'h25] = 8'h34;
		plain_map[7'h26] = 8'h33; plain_map[7'h29] = 8'h20; plain_map[7'h2A] = 8'h76;
		plain_map[7'h2B] = 8'h66; plain_map[7'h2C] = 8'h74; plain_map[7'h2D] = 8'h72;
		plain_map[7'h2E] = 8'h35; plain_map[7'h31] = 8'h6E; plain_map[7'h32] = 8'h62;
		plain_map[7'h33] = 8'h68; plain_map[7'h34] = 8'h67; plain_map[7'h35] = 8'h79;
		plain_map[7'h36] = 8'h36; plain_map[7'h3A] = 8'h6D; plain_map[7'h3B] = 8'h6A;
		plain_map[7'h3C] = 8'h75; plain_map[7'h3D] = 8'h37; plain_map[7'h3E] = 8'h38;
		plain_map[7'h41] = 8'h2C; plain_map[7'h42] = 8'h6B; plain_map[7'h43] = 8'h69;
		plain_map[7'h44] = 8'h6F; plain_map[7'h45] = 8'h30; plain_map[7'h46] = 8'h39;
		plain_map[7'h49] = 8'h2E; plain_map[7'h4A] = 8'h2F; plain_map[7'h4B] = 8'h6C;
		plain_map[7'h4C] = 8'h3B; plain_map[7'h4D] = 8'h70; plain_map[7'h4E] = 8'h2D;
		plain_map[7'h52] = 8'h27; plain_map[7'h54] = 8'h5B; plain_map[7'h55] = 8'h3D;
		plain_map[7'h5A] = 8'h0A; plain_map[7'h5B] = 8'h5D; plain_map[7'h5D] = 8'h5C;
		plain_map[7'h66] = 8'h08; plain_map[7'h69] = 8'h31; plain_map[7'h6B] = 8'h34;
		plain_map[7'h6C] = 8'h37; plain_map[7'h70] = 8'h30; plain_map[7'h71] = 8'h2E;
		plain_map[7'h72] = 8'h32; plain_map[7'h73] = 8'h35; plain_map[7'h74] = 8'h36;
		plain_map[7'h75] = 8'h38; plain_map[7'h79] = 8'h2B; plain_map[7'h7A] = 8'h33;
		plain_map[7'h7B] = 8'h2D; plain_map[7'h7C] = 8'h2A; plain_map[7'h7D] = 8'h39;
		for (int i = 0; i < 128; i++) begin
			if (plain_map[7'(i)] >= 8'h61 && plain_map[7'(i)] <= 8'h7A)
				shift_map[7'(i)] = plain_map[7'(i)] - 8'd32;
			else
				shift_map[7'(i)] = plain_map[7'(i)];
		end
		shift_map[7'h0E] = 8'h7E; shift_map[7'h16] = 8'h21; shift_map[7'h1E] = 8'h40;
		shift_map[7'h25] = 8'h24; shift_map[7'h26] = 8'h23; shift_map[7'h2E] = 8'h25;
		shift_map[7'h36] = 8'h5E; shift_map[7'h3D] = 8'h26; shift_map[7'h3E] = 8'h2A;
		shift_map[7'h41] = 8'h3C; shift_map[7'h45] = 8'h29; shift_map[7'h46] = 8'h28;
		shift_map[7'h49] = 8'h3E; shift_map[7'h4A] = 8'h3F; shift_map[7'h4C] = 8'h3A;
		shift_map[7'h4E] = 8'h5F; shift_map[7'h52] = 8'h22; shift_map[7'h54] = 8'h7B;
		shift_map[7'h55] = 8'h2B; shift_map[7'h5B] = 8'h7D; shift_map[7'h5D] = 8'h7C;
	end

	// character for a make code below 0x80
	function automatic logic [7:0] key_char(input logic [7:0] code);
		logic [7:0] c;
		case (code)
			ps2sc_pkg::CODE_ESC:   c = ps2sc_pkg::CHAR_ESC;
			ps2sc_pkg::CODE_UP:    c = ps2sc_pkg::CHAR_UP;
			ps2sc_pkg::CODE_DOWN:  c = ps2sc_pkg::CHAR_DOWN;
			ps2sc_pkg::CODE_LEFT:  c = ps2sc_pkg::CHAR_LEFT;
			ps2sc_pkg::CODE_RIGHT: c = ps2sc_pkg::CHAR_RIGHT;
			default: begin
				c = shift_q ? shift_map[code[6:0]] : plain_map[code[6:0]];
				if (caps_q && c >= 8'h61 && c <= 8'h7A)
					c = c - 8'd32;
				else if (caps_q && c >= 8'h41 && c <= 8'h5A)
					c = c + 8'd32;
			end
		endcase
		return c;
	endfunction

	// advances the modeled keyboard by one scan byte, returns the result word
	task automatic decode_scan_byte(input logic [7:0] code, output ps2sc_pkg::result_t r);
		logic [7:0] ch;
		logic       led;
		ch  = 8'h00;
		led = 1'b0;
		if (code == ps2sc_pkg::CODE_BREAK) begin
			brk_q = 1'b1;
		end else if (code == ps2sc_pkg::CODE_EXT) begin
			// extended prefix carries no meaning here
		end else if (brk_q) begin
			if (code == ps2sc_pkg::CODE_LSHIFT || code == ps2sc_pkg::CODE_RSHIFT)
				shift_q = 1'b0;
			else if (code == ps2sc_pkg::CODE_CTRL)
				ctrl_q = 1'b0;
			brk_q = 1'b0;
		end else if (code == ps2sc_pkg::CODE_LSHIFT || code == ps2sc_pkg::CODE_RSHIFT) begin
			shift_q = 1'b1;
		end else if (code == ps2sc_pkg::CODE_CTRL) begin
			ctrl_q = 1'b1;
		end else if (code == ps2sc_pkg::CODE_CAPS) begin
			caps_q = !caps_q;
			led    = 1'b1;
		end else if (!code[7]) begin
			ch = key_char(code);
		end
		r.char_valid = (ch != 8'h00);
		r.char_code  = ch;
		r.led_update = led;
		r.led_value  = {caps_q, 2'b00};
		r.shift_held = shift_q;
		r.ctrl_held  = ctrl_q;
		r.caps_on    = caps_q;
	endtask

	function automatic int field_diff(input string name, input int unsigned want,
			input int unsigned got);
		if (want == got) return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ps2sc_pkg::result_t want;
		ps2sc_pkg::result_t got;
		ps2sc_pkg::result_t next_word;
		if (!arst_n) begin
			brk_q   = 1'b0;
			shift_q = 1'b0;
			ctrl_q  = 1'b0;
			caps_q  = 1'b0;
			predicted_words.delete();
		end else begin
			// result side first; a word can never leave on the edge it entered
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (got.char_valid) chars_seen++;
				if (got.led_update) leds_seen++;
				if (predicted_words.size() == 0) begin
					$error("result word %h with nothing expected", m_axis_tdata);
					err_count++;
				end else begin
					want = predicted_words.pop_front();
					err_count += field_diff("char_valid", want.char_valid, got.char_valid)
						+ field_diff("char_code", want.char_code, got.char_code)
						+ field_diff("led_update", want.led_update, got.led_update)
						+ field_diff("led_value", want.led_value, got.led_value)
						+ field_diff("shift_held", want.shift_held, got.shift_held)
						+ field_diff("ctrl_held", want.ctrl_held, got.ctrl_held)
						+ field_diff("caps_on", want.caps_on, got.caps_on);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				decode_scan_byte(s_axis_tdata, next_word);
				predicted_words.push_back(next_word);
			end
		end
		words_pending = predicted_words.size();
	end

endmodule

### sim/ps2_scancode_to_ascii_decoder_unit_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the scan code decoder; all checking lives in the
// checker instance.
module ps2_scancode_to_ascii_decoder_unit_test;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_STALL} rx_mode_t;
	typedef enum logic [2:0] {
		SEQ_TYPE, SEQ_SHIFTED, SEQ_CTRL, SEQ_CAPS, SEQ_NAV, SEQ_NOISE, SEQ_BROKEN
	} seq_kind_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tready = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [15:0] m_axis_tdata;

	int err_count;
	int words_pending;
	int chars_seen;
	int leds_seen;
	int bytes_sent = 0;
	int burst_left = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ps2_scancode_to_ascii_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ps2_scancode_to_ascii_decoder_unit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.err_count     (err_count),
		.words_pending (words_pending),
		.chars_seen    (chars_seen),
		.leds_seen     (leds_seen)
	);

	// Receiver: switches between always ready, mostly ready, mostly stalled
	// and long stalls broken by single ready cycles.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= (rx_left % 12 == 0);
		endcase
	end

	// Presents one word and holds it until taken. Between bursts valid may
	// drop for a random gap; within a burst words follow back to back.
	task automatic put_byte(input logic [7:0] code);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= code;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// press of one key and usually its release, optionally behind the extended prefix
	task automatic tap_key(input logic [7:0] code, input logic ext);
		if (ext) put_byte(ps2sc_pkg::CODE_EXT);
		put_byte(code);
		if ($urandom_range(0, 3) != 0) begin
			if (ext) put_byte(ps2sc_pkg::CODE_EXT);
			put_byte(ps2sc_pkg::CODE_BREAK);
			put_byte(code);
		end
	endtask

	initial begin
		logic [7:0] opening [27];
		logic [7:0] nav_keys [5];
		logic [7:0] modifier;
		logic [7:0] key;
		seq_kind_t  kind;
		int         pick;
		opening = '{8'h00, 8'hFF, 8'h1C, ps2sc_pkg::CODE_LSHIFT, 8'h1C, 8'h0E,
			ps2sc_pkg::CODE_BREAK, ps2sc_pkg::CODE_LSHIFT, ps2sc_pkg::CODE_CAPS, 8'h1C,
			ps2sc_pkg::CODE_RSHIFT, 8'h1C, 8'h16,
			ps2sc_pkg::CODE_BREAK, ps2sc_pkg::CODE_BREAK, ps2sc_pkg::CODE_RSHIFT,
			ps2sc_pkg::CODE_CTRL, ps2sc_pkg::CODE_BREAK, ps2sc_pkg::CODE_CTRL,
			ps2sc_pkg::CODE_ESC, ps2sc_pkg::CODE_EXT, ps2sc_pkg::CODE_UP,
			ps2sc_pkg::CODE_DOWN, ps2sc_pkg::CODE_LEFT, ps2sc_pkg::CODE_RIGHT, 8'h80,
			ps2sc_pkg::CODE_CAPS};
		nav_keys = '{ps2sc_pkg::CODE_ESC, ps2sc_pkg::CODE_UP, ps2sc_pkg::CODE_DOWN,
			ps2sc_pkg::CODE_LEFT, ps2sc_pkg::CODE_RIGHT};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: table extremes, modifiers, caps with shift, breaks,
		// repeated break, extended prefix, forced keys, high and unmapped codes
		foreach (opening[i]) put_byte(opening[i]);
		put_byte(ps2sc_pkg::CODE_BREAK);
		put_byte(8'h1C);
		put_byte(8'h7F);

		// random: mostly well formed key traffic, the rest noise and stray prefixes
		while (bytes_sent < 730) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)      kind = SEQ_TYPE;
			else if (pick < 52) kind = SEQ_SHIFTED;
			else if (pick < 62) kind = SEQ_CTRL;
			else if (pick < 70) kind = SEQ_CAPS;
			else if (pick < 80) kind = SEQ_NAV;
			else if (pick < 90) kind = SEQ_NOISE;
			else                kind = SEQ_BROKEN;
			case (kind)
				SEQ_TYPE: begin
					tap_key(8'($urandom_range(0, 127)), 1'b0);
				end
				SEQ_SHIFTED, SEQ_CTRL: begin
					if (kind == SEQ_CTRL)
						modifier = ps2sc_pkg::CODE_CTRL;
					else
						modifier = $urandom_range(0, 1) ? ps2sc_pkg::CODE_LSHIFT
							: ps2sc_pkg::CODE_RSHIFT;
					put_byte(modifier);
					repeat ($urandom_range(1, 4)) tap_key(8'($urandom_range(0, 127)), 1'b0);
					// sometimes the modifier stays held into later sequences
					if ($urandom_range(0, 4) != 0) begin
						put_byte(ps2sc_pkg::CODE_BREAK);
						put_byte(modifier);
					end
				end
				SEQ_CAPS: begin
					tap_key(ps2sc_pkg::CODE_CAPS, 1'b0);
				end
				SEQ_NAV: begin
					key = nav_keys[3'($urandom_range(0, 4))];
					tap_key(key, key != ps2sc_pkg::CODE_ESC);
				end
				SEQ_NOISE: begin
					put_byte(8'($urandom_range(0, 255)));
				end
				default: begin
					case ($urandom_range(0, 3))
						0: begin
							put_byte(ps2sc_pkg::CODE_BREAK);
							put_byte(ps2sc_pkg::CODE_BREAK);
							put_byte(8'($urandom_range(0, 127)));
						end
						1: put_byte(ps2sc_pkg::CODE_EXT);
						2: begin
							put_byte(ps2sc_pkg::CODE_BREAK);
							put_byte(8'($urandom_range(0, 255)));
						end
						default: put_byte(8'($urandom_range(128, 255)));
					endcase
				end
			endcase
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain; the output register is one stage behind the input register
		while (words_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d scan bytes; saw %0d characters and %0d caps lock LED updates",
			bytes_sent, chars_seen, leds_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// safety net against a hung handshake
	initial begin
		#5ms;
		$display("Timeout with %0d words still expected", words_pending);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
